FILE: rtl/core/multi_reader_ring_buffer_unit_macros.svh
// Assertion macros for the multi-reader ring buffer checker.
// No dependencies; taken in by the checker file.
`ifndef MULTI_READER_RING_BUFFER_UNIT_MACROS_SVH
`define MULTI_READER_RING_BUFFER_UNIT_MACROS_SVH

// same-cycle implication
`define MRRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MRRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/mrrb_pkg.sv
// Shared types and constants for the multi-reader ring buffer.
// No dependencies.
package mrrb_pkg;

	localparam int unsigned MAX_CAPACITY_DEF = 2048;
	localparam int unsigned RING_DEPTH_DEF   = 2048;
	localparam int unsigned MAX_CURSORS_DEF  = 8;
	localparam int unsigned DATA_WIDTH_DEF   = 32;

	localparam int OPC_W      = 3;
	localparam int CUR_W      = 3;
	localparam int PAY_W      = 32;
	localparam int OFF_W      = 11;
	localparam int RCNT_W     = 12;
	localparam int ST_W       = 3;
	localparam int OCC_W      = 12;
	localparam int SEQ_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [SEQ_W-1:0] HALF_RANGE = 32'h8000_0000;

	localparam logic [11:0] SOFT_WARN_RST    = 12'd1024;
	localparam logic [11:0] SOFT_ERROR_RST   = 12'd2048;
	localparam logic [3:0]  CURSOR_COUNT_RST = 4'd1;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_PEEK    = 3'd1,
		OP_ACQUIRE = 3'd2,
		OP_RELEASE = 3'd3,
		OP_CLOSE   = 3'd4
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK          = 3'd0,
		ST_DISCARDED   = 3'd1,
		ST_FULL        = 3'd2,
		ST_THRESHOLD   = 3'd3,
		ST_CLOSED      = 3'd4,
		ST_NOT_READY   = 3'd5,
		ST_END         = 3'd6,
		ST_NOT_SLOWEST = 3'd7
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVERRUN      = 3'd0,
		REG_CAPACITY     = 3'd1,
		REG_SOFT_WARN    = 3'd2,
		REG_SOFT_ERROR   = 3'd3,
		REG_CURSOR_COUNT = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_PRE,
		S_EXEC,
		S_SCAN_SLOW,
		S_ACQ,
		S_SCAN_POST,
		S_DONE
	} seq_state_t;

endpackage

FILE: rtl/core/mrrb_ifs.sv
// Request, response and register-write channel interfaces.
// Depends on mrrb_pkg.
interface mrrb_req_if;
	logic                         valid;
	logic                         ready;
	logic [mrrb_pkg::OPC_W-1:0]   opcode;
	logic [mrrb_pkg::CUR_W-1:0]   cursor;
	logic [mrrb_pkg::PAY_W-1:0]   payload;
	logic [mrrb_pkg::OFF_W-1:0]   peek_offset;
	logic [mrrb_pkg::RCNT_W-1:0]  release_count;
	modport source (output valid, opcode, cursor, payload, peek_offset, release_count,
		input ready);
	modport sink (input valid, opcode, cursor, payload, peek_offset, release_count,
		output ready);
endinterface

interface mrrb_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mrrb_pkg::ST_W-1:0]    status;
	logic [mrrb_pkg::PAY_W-1:0]   read_data;
	logic [mrrb_pkg::OCC_W-1:0]   occupancy;
	logic [mrrb_pkg::SEQ_W-1:0]   dropped_total;
	logic [mrrb_pkg::SEQ_W-1:0]   cursor_dropped;
	logic                         warn_crossed;
	logic                         space_free;
	modport source (output valid, status, read_data, occupancy, dropped_total,
		cursor_dropped, warn_crossed, space_free, input ready);
	modport sink (input valid, status, read_data, occupancy, dropped_total,
		cursor_dropped, warn_crossed, space_free, output ready);
endinterface

interface mrrb_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mrrb_pkg::CFG_IDX_W-1:0]    index;
	logic [mrrb_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/mrrb_slot_ram.sv
// Slot store: single write port, single registered read port.
// No package dependencies.
module mrrb_slot_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 32,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/core/multi_reader_ring_buffer_unit.sv
// Multi-reader broadcast ring buffer, top level.
// Depends on mrrb_pkg, mrrb_ifs (channel interfaces) and mrrb_slot_ram.
//
//  channel | dir | handshake   | carries
//  req     | in  | valid/ready | opcode, cursor, payload, peek_offset, release_count
//  rsp     | out | valid/ready | status, read_data, occupancy, drop counts, flags
//  cfg     | in  | valid/ready | register index, write data
//
// A single shared subtract/compare unit walks the N attached cursor sequences one per
// cycle, before the operation and again after it (acquire adds a slowest check).
// arst_n resets config to its defaults and clears sequences, counters and flags; slot store is not cleared.
// req.ready is high only while idle; a held response stalls the next one at
// the final step. cfg is taken only while idle.
module multi_reader_ring_buffer_unit #(
	parameter int unsigned MAX_CAPACITY = mrrb_pkg::MAX_CAPACITY_DEF,
	parameter int unsigned RING_DEPTH   = mrrb_pkg::RING_DEPTH_DEF,
	parameter int unsigned MAX_CURSORS  = mrrb_pkg::MAX_CURSORS_DEF,
	parameter int unsigned DATA_WIDTH   = mrrb_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mrrb_req_if.sink    req,
	mrrb_rsp_if.source  rsp,
	mrrb_cfg_if.sink    cfg
);
	// size limit for all caps
	localparam int unsigned LIMIT = (MAX_CAPACITY < RING_DEPTH) ? MAX_CAPACITY : RING_DEPTH;
	localparam int HW  = ($clog2(LIMIT + 1) > 12) ? $clog2(LIMIT + 1) : 12;
	localparam int CIW = (MAX_CURSORS > 1) ? $clog2(MAX_CURSORS) : 1;
	localparam int CNW = $clog2(MAX_CURSORS + 1);
	localparam int AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SW  = mrrb_pkg::SEQ_W;

	// ---------------------------------------------------------------- config
	logic        overrun_q;
	logic [11:0] capacity_q;
	logic [11:0] soft_warn_q;
	logic [11:0] soft_error_q;
	logic [3:0]  cursor_count_q;

	// attached cursor count: saturated, at most one in drop-oldest mode
	function automatic logic [CNW-1:0] eff_n(input logic ovr, input logic [3:0] cc);
		logic [5:0] n;
		begin
			n = (6'(cc) > 6'(MAX_CURSORS)) ? 6'(MAX_CURSORS) : 6'(cc);
			if (ovr && n > 6'd1) begin
				n = 6'd1;
			end
			return CNW'(n);
		end
	endfunction

	logic [CNW-1:0] n_eff;
	logic [HW-1:0]  eff_err, eff_warn, eff_hard, cap_sat;

	assign n_eff    = eff_n(overrun_q, cursor_count_q);
	assign eff_warn = (capacity_q == '0) ? HW'(soft_warn_q) : '0;
	assign cap_sat  = (HW'(capacity_q) > HW'(LIMIT)) ? HW'(LIMIT) : HW'(capacity_q);
	always_comb begin
		if (capacity_q != '0) begin
			eff_err  = '0;
			eff_hard = cap_sat;
		end else begin
			eff_err  = (HW'(soft_error_q) > HW'(LIMIT)) ? HW'(LIMIT) : HW'(soft_error_q);
			eff_hard = (eff_err == '0) ? HW'(1) : eff_err;
		end
	end

	// cfg write: new register view, for cursor attach
	logic           cfg_fire;
	logic           ovr_new;
	logic [3:0]     cc_new;
	logic [CNW-1:0] n_after;
	mrrb_pkg::seq_state_t state_q, state_d;

	assign cfg.ready = (state_q == mrrb_pkg::S_IDLE);
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign ovr_new   = (cfg.index == mrrb_pkg::REG_OVERRUN) ? cfg.data[0] : overrun_q;
	assign cc_new    = (cfg.index == mrrb_pkg::REG_CURSOR_COUNT) ? cfg.data[3:0]
		: cursor_count_q;
	assign n_after   = eff_n(ovr_new, cc_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overrun_q      <= 1'b0;
			capacity_q     <= '0;
			soft_warn_q    <= mrrb_pkg::SOFT_WARN_RST;
			soft_error_q   <= mrrb_pkg::SOFT_ERROR_RST;
			cursor_count_q <= mrrb_pkg::CURSOR_COUNT_RST;
		end else if (cfg_fire) begin
			unique case (cfg.index)
				mrrb_pkg::REG_OVERRUN:      overrun_q      <= cfg.data[0];
				mrrb_pkg::REG_CAPACITY:     capacity_q     <= cfg.data;
				mrrb_pkg::REG_SOFT_WARN:    soft_warn_q    <= cfg.data;
				mrrb_pkg::REG_SOFT_ERROR:   soft_error_q   <= cfg.data;
				mrrb_pkg::REG_CURSOR_COUNT: cursor_count_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- state
	logic [SW-1:0] write_seq_q, drop_total_q;
	logic [SW-1:0] cursor_seq_q [MAX_CURSORS];
	logic [SW-1:0] drop_cnt_q   [MAX_CURSORS];
	logic          closed_q, warned_q;

	// latched request
	logic [2:0]                   op_q;
	logic [mrrb_pkg::CUR_W-1:0]   cur_q;
	logic [mrrb_pkg::PAY_W-1:0]   pay_q;
	logic [mrrb_pkg::OFF_W-1:0]   off_q;
	logic [mrrb_pkg::RCNT_W-1:0]  rel_q;
	logic [CIW-1:0]               cidx;
	logic                         attached;

	assign cidx     = CIW'(cur_q);
	assign attached = 8'(cur_q) < 8'(n_eff);

	// ---------------------------------------------------------------- scan unit
	// one cursor per cycle: distance to write_seq and lag behind cursor c
	logic [CNW-1:0] scan_cnt_q;
	logic [CIW-1:0] sidx;
	logic           scan_on, scan_is_c;
	logic [SW-1:0]  scan_seq, scan_dist, scan_lag;
	logic [SW-1:0]  maxd_q, cs_q;
	logic           notslow_q;

	assign sidx      = scan_cnt_q[CIW-1:0];
	assign scan_on   = scan_cnt_q < n_eff;
	assign scan_seq  = cursor_seq_q[sidx];
	assign scan_dist = write_seq_q - scan_seq;
	assign scan_lag  = cs_q - scan_seq;
	assign scan_is_c = 8'(sidx) == 8'(cur_q);

	// ---------------------------------------------------------------- operation
	mrrb_pkg::status_t ex_status;
	logic          ex_warn, ex_write, ex_drop, ex_peek_hit, ex_acq_scan, ex_rel_we;
	logic [SW-1:0] ex_need, ex_target, ex_peek_d, ex_room, ex_rel_seq;
	logic [SW-1:0] err32, warn32, hard32;

	assign err32     = SW'(eff_err);
	assign warn32    = SW'(eff_warn);
	assign hard32    = SW'(eff_hard);
	assign ex_need   = maxd_q - hard32 + SW'(1);
	assign ex_target = cs_q + SW'(off_q);
	assign ex_peek_d = write_seq_q - ex_target;
	assign ex_room   = write_seq_q - cs_q;
	assign ex_rel_seq = (SW'(rel_q) >= ex_room) ? write_seq_q : cs_q + SW'(rel_q);

	always_comb begin
		ex_status   = mrrb_pkg::ST_OK;
		ex_warn     = 1'b0;
		ex_write    = 1'b0;
		ex_drop     = 1'b0;
		ex_peek_hit = 1'b0;
		ex_acq_scan = 1'b0;
		ex_rel_we   = 1'b0;
		if (op_q == mrrb_pkg::OP_PUSH) begin
			priority if (closed_q) begin
				ex_status = mrrb_pkg::ST_CLOSED;
			end else if (n_eff == '0) begin
				ex_status = mrrb_pkg::ST_DISCARDED;
			end else if (err32 != '0 && maxd_q >= err32) begin
				ex_status = mrrb_pkg::ST_THRESHOLD;
			end else begin
				// warning is raised even if this push is then refused as full
				ex_warn = (warn32 != '0) && !warned_q && (maxd_q >= warn32);
				if (err32 == '0 && maxd_q >= hard32 && !overrun_q) begin
					ex_status = mrrb_pkg::ST_FULL;
				end else begin
					ex_drop  = (err32 == '0) && (maxd_q >= hard32);
					ex_write = 1'b1;
				end
			end
		end else if ((op_q == mrrb_pkg::OP_PEEK || op_q == mrrb_pkg::OP_ACQUIRE
				|| op_q == mrrb_pkg::OP_RELEASE) && !attached) begin
			ex_status = mrrb_pkg::ST_NOT_READY;
		end else if (op_q == mrrb_pkg::OP_PEEK) begin
			if (ex_peek_d != '0 && ex_peek_d < mrrb_pkg::HALF_RANGE) begin
				ex_peek_hit = 1'b1;
			end else begin
				ex_status = closed_q ? mrrb_pkg::ST_END : mrrb_pkg::ST_NOT_READY;
			end
		end else if (op_q == mrrb_pkg::OP_ACQUIRE) begin
			if (write_seq_q == cs_q) begin
				ex_status = closed_q ? mrrb_pkg::ST_END : mrrb_pkg::ST_NOT_READY;
			end else begin
				ex_acq_scan = 1'b1;
			end
		end else if (op_q == mrrb_pkg::OP_RELEASE) begin
			ex_rel_we = (rel_q != '0);
		end
	end

	// ---------------------------------------------------------------- sequencer
	logic rsp_load;
	assign req.ready = (state_q == mrrb_pkg::S_IDLE);
	assign rsp_load  = (state_q == mrrb_pkg::S_DONE) && (!rsp.valid || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrrb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrrb_pkg::S_IDLE:      if (req.valid) state_d = mrrb_pkg::S_SCAN_PRE;
			mrrb_pkg::S_SCAN_PRE:  if (!scan_on) state_d = mrrb_pkg::S_EXEC;
			mrrb_pkg::S_EXEC: begin
				state_d = ex_acq_scan ? mrrb_pkg::S_SCAN_SLOW : mrrb_pkg::S_SCAN_POST;
			end
			mrrb_pkg::S_SCAN_SLOW: if (!scan_on) state_d = mrrb_pkg::S_ACQ;
			mrrb_pkg::S_ACQ:       state_d = mrrb_pkg::S_SCAN_POST;
			mrrb_pkg::S_SCAN_POST: if (!scan_on) state_d = mrrb_pkg::S_DONE;
			mrrb_pkg::S_DONE:      if (rsp_load) state_d = mrrb_pkg::S_IDLE;
			default:               state_d = mrrb_pkg::S_IDLE;
		endcase
	end

	// scan counter restarts on entry to every scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
		end else if (state_d != state_q) begin
			scan_cnt_q <= '0;
		end else if (scan_on) begin
			scan_cnt_q <= scan_cnt_q + CNW'(1);
		end
	end

	// working registers
	logic acq_ok;
	assign acq_ok = (state_q == mrrb_pkg::S_ACQ) && !notslow_q;

	mrrb_pkg::status_t status_q;
	logic warn_q, rd_hit_q;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q      <= req.opcode;
			cur_q     <= req.cursor;
			pay_q     <= req.payload;
			off_q     <= req.peek_offset;
			rel_q     <= req.release_count;
			maxd_q    <= '0;
			cs_q      <= '0;
			notslow_q <= 1'b0;
			rd_hit_q  <= 1'b0;
		end
		unique case (state_q)
			mrrb_pkg::S_SCAN_PRE: begin
				if (scan_on) begin
					if (scan_dist > maxd_q) maxd_q <= scan_dist;
					if (scan_is_c) cs_q <= scan_seq;
				end
			end
			mrrb_pkg::S_EXEC: begin
				status_q <= ex_status;
				warn_q   <= ex_warn;
				rd_hit_q <= ex_peek_hit;
				maxd_q   <= '0;
			end
			mrrb_pkg::S_SCAN_SLOW: begin
				if (scan_on && !scan_is_c && scan_lag <= SW'(MAX_CAPACITY)) begin
					notslow_q <= 1'b1;
				end
			end
			mrrb_pkg::S_ACQ: begin
				status_q <= notslow_q ? mrrb_pkg::ST_NOT_SLOWEST : mrrb_pkg::ST_OK;
				rd_hit_q <= !notslow_q;
			end
			mrrb_pkg::S_SCAN_POST: begin
				if (scan_on && scan_dist > maxd_q) maxd_q <= scan_dist;
			end
			default: ;
		endcase
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_seq_q  <= '0;
			drop_total_q <= '0;
			closed_q     <= 1'b0;
			warned_q     <= 1'b0;
			for (int i = 0; i < int'(MAX_CURSORS); i++) begin
				cursor_seq_q[i] <= '0;
				drop_cnt_q[i]   <= '0;
			end
		end else if (cfg_fire) begin
			// newly attached cursors start at the write position
			for (int i = 0; i < int'(MAX_CURSORS); i++) begin
				if (i >= int'(n_eff) && i < int'(n_after)) begin
					cursor_seq_q[i] <= write_seq_q;
					drop_cnt_q[i]   <= '0;
				end
			end
		end else if (state_q == mrrb_pkg::S_EXEC) begin
			if (ex_warn) warned_q <= 1'b1;
			if (ex_write) write_seq_q <= write_seq_q + SW'(1);
			if (ex_drop) begin
				cursor_seq_q[0] <= cursor_seq_q[0] + ex_need;
				drop_cnt_q[0]   <= drop_cnt_q[0] + ex_need;
				drop_total_q    <= drop_total_q + ex_need;
			end
			if (ex_rel_we) cursor_seq_q[cidx] <= ex_rel_seq;
			if (op_q == mrrb_pkg::OP_CLOSE) closed_q <= 1'b1;
		end else if (acq_ok) begin
			cursor_seq_q[cidx] <= cs_q + SW'(1);
		end
	end

	// ---------------------------------------------------------------- slot store
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
	logic [63:0]           wide_wr, wide_rd;

	assign wide_wr   = 64'(pay_q);
	assign mem_wdata = wide_wr[DATA_WIDTH-1:0];
	assign wide_rd   = 64'(mem_rdata);
	assign mem_we    = (state_q == mrrb_pkg::S_EXEC) && ex_write;
	assign mem_waddr = AW'(write_seq_q % SW'(RING_DEPTH));
	assign mem_re    = ((state_q == mrrb_pkg::S_EXEC) && ex_peek_hit) || acq_ok;
	assign mem_raddr = (state_q == mrrb_pkg::S_EXEC) ? AW'(ex_target % SW'(RING_DEPTH))
		: AW'(cs_q % SW'(RING_DEPTH));

	mrrb_slot_ram #(
		.DEPTH (RING_DEPTH),
		.WIDTH (DATA_WIDTH),
		.AW    (AW)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// ---------------------------------------------------------------- response
	logic                         rsp_valid_q;
	logic [mrrb_pkg::ST_W-1:0]    rsp_status_q;
	logic [mrrb_pkg::PAY_W-1:0]   rsp_data_q;
	logic [mrrb_pkg::OCC_W-1:0]   rsp_occ_q;
	logic [SW-1:0]                rsp_drop_total_q, rsp_cur_drop_q;
	logic                         rsp_warn_q, rsp_free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q     <= status_q;
			rsp_data_q       <= rd_hit_q ? wide_rd[mrrb_pkg::PAY_W-1:0] : '0;
			rsp_occ_q        <= (maxd_q > SW'(12'hFFF)) ? 12'hFFF : maxd_q[11:0];
			rsp_drop_total_q <= drop_total_q;
			rsp_cur_drop_q   <= (32'(cur_q) < 32'(MAX_CURSORS)) ? drop_cnt_q[cidx] : '0;
			rsp_warn_q       <= warn_q;
			rsp_free_q       <= maxd_q < hard32;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.read_data      = rsp_data_q;
	assign rsp.occupancy      = rsp_occ_q;
	assign rsp.dropped_total  = rsp_drop_total_q;
	assign rsp.cursor_dropped = rsp_cur_drop_q;
	assign rsp.warn_crossed   = rsp_warn_q;
	assign rsp.space_free     = rsp_free_q;
endmodule

FILE: rtl/core/mrrb_checker.sv
// Port-level checker for the multi-reader ring buffer, bound to the top level.
// Depends on mrrb_pkg and multi_reader_ring_buffer_unit_macros.svh.
`include "multi_reader_ring_buffer_unit_macros.svh"

module mrrb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [mrrb_pkg::ST_W-1:0]   rsp_status,
	input logic [mrrb_pkg::PAY_W-1:0]  rsp_read_data,
	input logic [mrrb_pkg::OCC_W-1:0]  rsp_occupancy,
	input logic                        rsp_warn,
	input logic                        rsp_space_free
);
	`MRRB_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready, "ready after request")
	`MRRB_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_read_data), "stalled response changed")
	`MRRB_ASSERT_NOW(a_discard_empty, clk, arst_n, rsp_valid && rsp_status == mrrb_pkg::ST_DISCARDED, rsp_occupancy == '0, "discard with occupancy")
	`MRRB_ASSERT_NOW(a_full_no_space, clk, arst_n, rsp_valid && rsp_status == mrrb_pkg::ST_FULL, !rsp_space_free, "full but space free")
	`MRRB_ASSERT_NOW(a_warn_push, clk, arst_n, rsp_valid && rsp_warn, rsp_status == mrrb_pkg::ST_OK || rsp_status == mrrb_pkg::ST_FULL, "warn on failed push")
endmodule

bind multi_reader_ring_buffer_unit mrrb_checker u_mrrb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_read_data  (rsp.read_data),
	.rsp_occupancy  (rsp.occupancy),
	.rsp_warn       (rsp.warn_crossed),
	.rsp_space_free (rsp.space_free)
);

FILE: bench/multi_reader_ring_buffer_unit_chk.sv
// Checker for the multi-reader ring buffer: watches request, response and register channels,
// predicts each response and compares it field by field. Depends on mrrb_pkg and mrrb_ifs.
`timescale 1ns / 1ps
module multi_reader_ring_buffer_unit_chk
	import mrrb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mrrb_req_if         req,
	mrrb_rsp_if         rsp,
	mrrb_cfg_if         cfg,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [PAY_W-1:0] read_data;
		logic [OCC_W-1:0] occupancy;
		logic [31:0]      dropped_total;
		logic [31:0]      cursor_dropped;
		logic             warn_crossed;
		logic             space_free;
	} ring_result_t;

	localparam int unsigned DEPTH = RING_DEPTH_DEF;
	localparam int unsigned NCUR  = MAX_CURSORS_DEF;

	logic        mode_drop;
	logic [11:0] cap_reg, warn_reg, err_reg;
	logic [3:0]  ncur_reg;
	logic [31:0] wr_seq, drops;
	logic [31:0] rd_seq [NCUR];
	logic [31:0] rd_drops [NCUR];
	logic [31:0] slots [DEPTH];
	logic        is_closed, has_warned;

	// expected responses, oldest at due_rd; at most two are ever outstanding
	ring_result_t due_mem [4];
	logic [1:0]   due_wr, due_rd;
	int           due_cnt;

	function automatic int unsigned err_level();
		if (cap_reg != 0) return 0;
		return (err_reg > MAX_CAPACITY_DEF) ? MAX_CAPACITY_DEF : err_reg;
	endfunction

	function automatic int unsigned hard_level();
		int unsigned h;
		h = (cap_reg == 0) ? err_level() : cap_reg;
		if (h > MAX_CAPACITY_DEF) h = MAX_CAPACITY_DEF;
		if (h < 1) h = 1;
		return h;
	endfunction

	function automatic int unsigned live_cursors();
		int unsigned n;
		n = (ncur_reg > NCUR) ? NCUR : ncur_reg;
		if (mode_drop && n > 1) n = 1;
		return n;
	endfunction

	function automatic logic [31:0] fill_level();
		logic [31:0] best, d;
		best = 0;
		for (int i = 0; i < live_cursors(); i++) begin
			d = wr_seq - rd_seq[i];
			if (d > best) best = d;
		end
		return best;
	endfunction

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
		int unsigned was, now;
		was = live_cursors();
		case (idx)
			REG_OVERRUN: begin
				mode_drop = val[0];
			end
			REG_CAPACITY: begin
				cap_reg = val;
			end
			REG_SOFT_WARN: begin
				warn_reg = val;
			end
			REG_SOFT_ERROR: begin
				err_reg = val;
			end
			REG_CURSOR_COUNT: begin
				ncur_reg = val[3:0];
			end
			default: return;
		endcase
		now = live_cursors();
		for (int i = was; i < now; i++) begin
			rd_seq[i] = wr_seq;
			rd_drops[i] = 0;
		end
	endtask

	function automatic ring_result_t serve(input logic [2:0] op, input logic [2:0] c,
		input logic [31:0] pay, input logic [10:0] off, input logic [11:0] cnt);
		ring_result_t r;
		int unsigned n, errl, hard;
		logic [31:0] act, tgt, d, cs, need, room;
		n = live_cursors();
		r = '0;
		r.status = ST_OK;
		if (op == OP_PUSH) begin
			act = fill_level();
			errl = err_level();
			hard = hard_level();
			if (is_closed) r.status = ST_CLOSED;
			else if (n == 0) r.status = ST_DISCARDED;
			else if (errl != 0 && act >= errl) r.status = ST_THRESHOLD;
			else begin
				if (cap_reg == 0 && warn_reg != 0 && !has_warned && act >= warn_reg) begin
					has_warned = 1;
					r.warn_crossed = 1;
				end
				if (errl == 0 && act >= hard && !mode_drop) r.status = ST_FULL;
				else begin
					if (errl == 0 && act >= hard) begin
						need = act - hard + 1;
						rd_seq[0] += need;
						rd_drops[0] += need;
						drops += need;
					end
					slots[wr_seq % DEPTH] = pay;
					wr_seq++;
				end
			end
		end else if (op >= OP_PEEK && op <= OP_RELEASE && c >= n) begin
			r.status = ST_NOT_READY;
		end else if (op == OP_PEEK) begin
			tgt = rd_seq[c] + off;
			d = wr_seq - tgt;
			if (d > 0 && d < HALF_RANGE) r.read_data = slots[tgt % DEPTH];
			else r.status = is_closed ? ST_END : ST_NOT_READY;
		end else if (op == OP_ACQUIRE) begin
			cs = rd_seq[c];
			if (wr_seq == cs) r.status = is_closed ? ST_END : ST_NOT_READY;
			else begin
				for (int i = 0; i < n; i++)
					if (i != c && (cs - rd_seq[i]) <= MAX_CAPACITY_DEF) r.status = ST_NOT_SLOWEST;
				if (r.status == ST_OK) begin
					r.read_data = slots[cs % DEPTH];
					rd_seq[c] = cs + 1;
				end
			end
		end else if (op == OP_RELEASE) begin
			if (cnt != 0) begin
				room = wr_seq - rd_seq[c];
				rd_seq[c] = (cnt >= room) ? wr_seq : rd_seq[c] + cnt;
			end
		end else if (op == OP_CLOSE) begin
			is_closed = 1;
		end
		act = fill_level();
		r.occupancy = (act > 12'hFFF) ? 12'hFFF : act[11:0];
		r.dropped_total = drops;
		r.cursor_dropped = rd_drops[c];
		r.space_free = act < hard_level();
		return r;
	endfunction

	assign pending = due_cnt;

	always @(posedge clk or negedge arst_n) begin
		ring_result_t want;
		if (!arst_n) begin
			mode_drop = 0; cap_reg = 0; warn_reg = SOFT_WARN_RST;
			err_reg = SOFT_ERROR_RST; ncur_reg = CURSOR_COUNT_RST;
			wr_seq = 0; drops = 0; is_closed = 0; has_warned = 0;
			for (int i = 0; i < NCUR; i++) begin
				rd_seq[i] = 0;
				rd_drops[i] = 0;
			end
			due_wr = 0;
			due_rd = 0;
			due_cnt = 0;
			fail_count = 0;
		end else begin
			// response first: it belongs to an earlier request
			if (rsp.valid && rsp.ready) begin
				if (due_cnt == 0) begin
					$error("response with nothing outstanding");
					fail_count++;
				end else begin
					want = due_mem[due_rd];
					due_rd++;
					due_cnt--;
					if (rsp.status !== want.status) begin
						$error("status exp %0d got %0d", want.status, rsp.status); fail_count++;
					end
					if (rsp.read_data !== want.read_data) begin
						$error("read_data exp %h got %h", want.read_data, rsp.read_data);
						fail_count++;
					end
					if (rsp.occupancy !== want.occupancy) begin
						$error("occupancy exp %0d got %0d", want.occupancy, rsp.occupancy);
						fail_count++;
					end
					if (rsp.dropped_total !== want.dropped_total) begin
						$error("dropped_total exp %0d got %0d", want.dropped_total,
							rsp.dropped_total);
						fail_count++;
					end
					if (rsp.cursor_dropped !== want.cursor_dropped) begin
						$error("cursor_dropped exp %0d got %0d", want.cursor_dropped,
							rsp.cursor_dropped);
						fail_count++;
					end
					if (rsp.warn_crossed !== want.warn_crossed) begin
						$error("warn_crossed exp %0d got %0d", want.warn_crossed,
							rsp.warn_crossed);
						fail_count++;
					end
					if (rsp.space_free !== want.space_free) begin
						$error("space_free exp %0d got %0d", want.space_free, rsp.space_free);
						fail_count++;
					end
				end
			end
			if (cfg.valid && cfg.ready) apply_reg(cfg.index, cfg.data);
			if (req.valid && req.ready) begin
				if (due_cnt == 4) begin
					$error("too many requests outstanding");
					fail_count++;
				end else begin
					due_mem[due_wr] = serve(req.opcode, req.cursor, req.payload,
						req.peek_offset, req.release_count);
					due_wr++;
					due_cnt++;
				end
			end
		end
	end

endmodule

FILE: bench/multi_reader_ring_buffer_unit_tb.sv
// Testbench top for the multi-reader ring buffer: clock, reset, requests, register writes
// and response back-pressure. Depends on mrrb_pkg, mrrb_ifs, the ring buffer unit and the checker module.
`timescale 1ns / 1ps
module multi_reader_ring_buffer_unit_tb;
	import mrrb_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles;
	bit   sink_busy;

	mrrb_req_if req ();
	mrrb_rsp_if rsp ();
	mrrb_cfg_if cfg ();

	multi_reader_ring_buffer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	multi_reader_ring_buffer_unit_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// response back-pressure: while sink_busy is set, each taken response may be followed by a random stall
	initial begin
		int gap;
		rsp.ready = 0;
		@(posedge arst_n);
		@(posedge clk);
		rsp.ready <= 1;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				gap = sink_busy ? $urandom_range(0, 6) : 0;
				if (gap != 0) begin
					rsp.ready <= 0;
					repeat (gap) @(posedge clk);
					rsp.ready <= 1;
				end
			end
		end
	end

	// watchdog: worst case ~800 requests plus stalls, taken many times over
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// one request through the handshake, after a random idle gap when gaps is set
	task automatic send(input opcode_t op, input logic [2:0] c, input logic [31:0] pay,
		input logic [10:0] off, input logic [11:0] cnt, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 6) : 0;
		repeat (gap) @(posedge clk);
		req.valid <= 1;
		req.opcode <= op;
		req.cursor <= c;
		req.payload <= pay;
		req.peek_offset <= off;
		req.release_count <= cnt;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		req.valid <= 0;
		@(posedge clk);
	endtask

	// raw opcode, covers the unused codes too
	task automatic send_raw(input logic [2:0] op, input logic [2:0] c, input logic [31:0] pay,
		input logic [10:0] off, input logic [11:0] cnt);
		send(opcode_t'(op), c, pay, off, cnt, 1);
	endtask

	// wait until every response has come, then let the block settle
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [11:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	// random phase: push-heavy with peeks/acquires/releases and unused opcodes; close only when asked for
	task automatic random_phase(input int n, input int ncur, input int maxrel, input bit closing);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 45)
				send(OP_PUSH, 3'($urandom), $urandom, 11'($urandom), 12'($urandom), 1);
			else if (k < 60)
				send(OP_PEEK, 3'($urandom_range(0, ncur)), $urandom,
					($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 4)),
					12'($urandom), 1);
			else if (k < 80)
				send(OP_ACQUIRE, 3'($urandom_range(0, ncur)), $urandom, 11'($urandom),
					12'($urandom), 1);
			else if (k < 97)
				send(OP_RELEASE, 3'($urandom_range(0, ncur)), $urandom, 11'($urandom),
					($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, maxrel)),
					1);
			else if (k < 98 || !closing)
				send_raw(3'($urandom_range(5, 7)), 3'($urandom), $urandom, 11'($urandom),
					12'($urandom));
			else
				send(OP_CLOSE, 3'($urandom), $urandom, 11'($urandom), 12'($urandom), 1);
		end
	endtask

	initial begin
		req.valid = 0; req.opcode = OP_PUSH; req.cursor = 0; req.payload = 0;
		req.peek_offset = 0; req.release_count = 0;
		cfg.valid = 0; cfg.index = REG_OVERRUN; cfg.data = 0;
		sink_busy = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset config, single cursor; the first reads come before anything is written
		send(OP_PEEK, 0, 0, 0, 0, 0);            // empty peek: not ready
		send(OP_ACQUIRE, 0, 0, 0, 0, 0);         // empty acquire
		send(OP_PEEK, 7, 0, 0, 0, 0);            // unattached cursor
		send(OP_PUSH, 7, 32'hFFFF_FFFF, 11'h7FF, 12'hFFF, 0);
		send(OP_PUSH, 0, 32'h0, 0, 0, 0);
		send(OP_PEEK, 0, 0, 1, 0, 0);
		send(OP_PEEK, 0, 0, 11'h7FF, 0, 0);      // beyond write position
		send(OP_ACQUIRE, 0, 0, 0, 0, 0);
		send(OP_RELEASE, 0, 0, 0, 0, 0);         // zero count does nothing
		send(OP_RELEASE, 0, 0, 0, 12'd2048, 0);  // saturates at write position
		send_raw(3'd7, 3'd5, 32'h1234_5678, 0, 0);
		drain();

		// default levels, one cursor
		sink_busy = 1;
		random_phase(160, 1, 3, 0);
		drain();

		// four cursors, low warn and error levels
		write_reg(REG_CURSOR_COUNT, 12'd4);
		write_reg(REG_SOFT_WARN, 12'd6);
		write_reg(REG_SOFT_ERROR, 12'd24);
		random_phase(160, 4, 6, 0);
		drain();

		// explicit hard cap, pushes refused when full
		write_reg(REG_CAPACITY, 12'd12);
		write_reg(REG_CURSOR_COUNT, 12'd3);
		random_phase(160, 3, 4, 0);
		drain();

		// drop-oldest: cursor count forced to one
		write_reg(REG_OVERRUN, 12'd1);
		write_reg(REG_CURSOR_COUNT, 12'd8);
		write_reg(REG_CAPACITY, 12'd8);
		random_phase(160, 1, 2, 0);
		drain();

		// no cursors: pushes are discarded
		write_reg(REG_CURSOR_COUNT, 12'd0);
		random_phase(30, 1, 2, 0);
		drain();

		// saturated cap and cursor count, closes allowed
		write_reg(REG_OVERRUN, 12'd0);
		write_reg(REG_CAPACITY, 12'hFFF);
		write_reg(REG_CURSOR_COUNT, 12'hF);
		random_phase(100, 7, 8, 1);
		drain();

		// close, repeated close, then pushes and reads on a closed stream
		send(OP_CLOSE, 0, 0, 0, 0, 0);
		send(OP_CLOSE, 0, 0, 0, 0, 0);           // already closed
		send(OP_PUSH, 0, 32'hA5A5_A5A5, 0, 0, 0);
		send(OP_ACQUIRE, 0, 0, 0, 0, 0);
		send(OP_PEEK, 0, 0, 11'h7FF, 0, 0);      // end of stream
		drain();

		if (fail_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/mrrb_pkg.sv
rtl/core/mrrb_ifs.sv
rtl/core/mrrb_slot_ram.sv
rtl/core/multi_reader_ring_buffer_unit.sv
rtl/core/mrrb_checker.sv
bench/multi_reader_ring_buffer_unit_chk.sv
bench/multi_reader_ring_buffer_unit_tb.sv
